@@ sv/ldpm_pkg.sv @@
`default_nettype none

package ldpm_pkg;

  localparam int NumStages = 10;
  localparam int PrepStages = 3;
  localparam int ProdStages = 5;
  localparam int SumStages = 2;

  localparam int PtShift = 44;
  localparam int K1Shift = 60;
  localparam int K2Shift = 92;

  localparam logic [65:0] PtHalf = 66'd1 << (PtShift - 1);
  localparam logic [80:0] K1Half = 81'd1 << (K1Shift - 1);
  localparam logic [113:0] K2Half = 114'd1 << (K2Shift - 1);

  typedef enum logic [2:0] {
    RegK1,
    RegK2,
    RegP1,
    RegP2,
    RegCx,
    RegCy,
    RegMode
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] mk1;
    logic [31:0] mk2;
    logic [31:0] mp1;
    logic [31:0] mp2;
    logic        nk1;
    logic        nk2;
    logic        np1;
    logic        np2;
    logic [15:0] cx;
    logic [15:0] cy;
    logic        mode;
  } cfg_t;

  // offsets from center as magnitude and sign, plus the coordinate the terms add to
  typedef struct packed {
    logic [15:0] au;
    logic [15:0] av;
    logic        nu;
    logic        nv;
    logic [16:0] bx;
    logic [16:0] by;
  } pnt_t;

  typedef struct packed {
    pnt_t        p;
    logic [32:0] r2;
    logic [32:0] uv2;
    logic [33:0] t1;
    logic [33:0] t2;
  } sums_t;

  typedef struct packed {
    logic        nu;
    logic        nv;
    logic [16:0] bx;
    logic [16:0] by;
    logic [20:0] k1x;
    logic [20:0] k1y;
    logic [21:0] k2x;
    logic [21:0] k2y;
    logic [21:0] p1x;
    logic [21:0] p2x;
    logic [21:0] p1y;
    logic [21:0] p2y;
  } terms_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    logic [31:0] n;
    n = 32'd0 - v;
    return v[31] ? n : v;
  endfunction

  function automatic logic [21:0] round_pt(input logic [64:0] q);
    logic [65:0] s;
    s = {1'b0, q} + PtHalf;
    return s[65:PtShift];
  endfunction

  function automatic logic [25:0] apply_sign(input logic [21:0] m, input logic neg);
    logic [25:0] e;
    e = {4'd0, m};
    return neg ? (26'd0 - e) : e;
  endfunction

endpackage

`default_nettype wire

@@ sv/ldpm_prep.sv @@
`default_nettype none

module ldpm_prep (
  input  wire logic                                clk,
  input  wire logic [ldpm_pkg::PrepStages-1:0]     en,
  input  wire ldpm_pkg::cfg_t                      cfg,
  input  wire logic [15:0]                         in_x,
  input  wire logic [15:0]                         in_y,
  input  wire logic [15:0]                         in_target_x,
  input  wire logic [15:0]                         in_target_y,
  output ldpm_pkg::sums_t                          sums
);

  typedef struct packed {
    ldpm_pkg::pnt_t p;
    logic [31:0]    u2;
    logic [31:0]    v2;
    logic [31:0]    uv;
  } sqr_t;

  ldpm_pkg::pnt_t  s1_r, s1_nxt;
  sqr_t            s2_r, s2_nxt;
  ldpm_pkg::sums_t s3_r, s3_nxt;

  logic [16:0] u, v, un, vn, xe, ye;

  // offsets from center, base coordinate
  always_comb begin
    xe = {in_x[15], in_x};
    ye = {in_y[15], in_y};
    u  = xe - {cfg.cx[15], cfg.cx};
    v  = ye - {cfg.cy[15], cfg.cy};
    un = 17'd0 - u;
    vn = 17'd0 - v;
    s1_nxt.nu = u[16];
    s1_nxt.nv = v[16];
    s1_nxt.au = u[16] ? un[15:0] : u[15:0];
    s1_nxt.av = v[16] ? vn[15:0] : v[15:0];
    s1_nxt.bx = cfg.mode ? (xe - {in_target_x[15], in_target_x}) : xe;
    s1_nxt.by = cfg.mode ? (ye - {in_target_y[15], in_target_y}) : ye;
  end

  // squares and cross product
  always_comb begin
    s2_nxt.p  = s1_r;
    s2_nxt.u2 = 32'(s1_r.au) * 32'(s1_r.au);
    s2_nxt.v2 = 32'(s1_r.av) * 32'(s1_r.av);
    s2_nxt.uv = 32'(s1_r.au) * 32'(s1_r.av);
  end

  // radius and tangential sums
  always_comb begin
    s3_nxt.p   = s2_r.p;
    s3_nxt.r2  = 33'(s2_r.u2) + 33'(s2_r.v2);
    s3_nxt.uv2 = {s2_r.uv, 1'b0};
    s3_nxt.t1  = (34'(s2_r.u2) << 1) + 34'(s2_r.u2) + 34'(s2_r.v2);
    s3_nxt.t2  = (34'(s2_r.v2) << 1) + 34'(s2_r.v2) + 34'(s2_r.u2);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
  end

  assign sums = s3_r;

endmodule

`default_nettype wire

@@ sv/ldpm_prod.sv @@
`default_nettype none

module ldpm_prod (
  input  wire logic                            clk,
  input  wire logic [ldpm_pkg::ProdStages-1:0] en,
  input  wire ldpm_pkg::cfg_t                  cfg,
  input  wire ldpm_pkg::sums_t                 sums,
  output ldpm_pkg::terms_t                     terms
);

  typedef struct packed {
    ldpm_pkg::pnt_t p;
    logic [32:0]    r2;
    logic [63:0]    a;
    logic [63:0]    b;
    logic [64:0]    q1x;
    logic [64:0]    q2x;
    logic [64:0]    q1y;
    logic [64:0]    q2y;
  } s4_t;

  typedef struct packed {
    ldpm_pkg::pnt_t p;
    logic [64:0]    cl;
    logic [64:0]    ch;
    logic [47:0]    xl;
    logic [47:0]    xh;
    logic [47:0]    yl;
    logic [47:0]    yh;
    logic [21:0]    p1x;
    logic [21:0]    p2x;
    logic [21:0]    p1y;
    logic [21:0]    p2y;
  } s5_t;

  typedef struct packed {
    ldpm_pkg::pnt_t p;
    logic [96:0]    c;
    logic [20:0]    k1x;
    logic [20:0]    k1y;
    logic [21:0]    p1x;
    logic [21:0]    p2x;
    logic [21:0]    p1y;
    logic [21:0]    p2y;
  } s6_t;

  typedef struct packed {
    ldpm_pkg::pnt_t p;
    logic [20:0]    k1x;
    logic [20:0]    k1y;
    logic [21:0]    p1x;
    logic [21:0]    p2x;
    logic [21:0]    p1y;
    logic [21:0]    p2y;
    logic [48:0]    d0x;
    logic [48:0]    d1x;
    logic [46:0]    d2x;
    logic [48:0]    d0y;
    logic [48:0]    d1y;
    logic [46:0]    d2y;
  } s7_t;

  s4_t              s4_r, s4_nxt;
  s5_t              s5_r, s5_nxt;
  s6_t              s6_r, s6_nxt;
  s7_t              s7_r, s7_nxt;
  ldpm_pkg::terms_t s8_r, s8_nxt;

  logic [80:0]  x1, y1;
  logic [113:0] dx, dy;

  // radial coefficient times r2, tangential products
  always_comb begin
    s4_nxt.p   = sums.p;
    s4_nxt.r2  = sums.r2;
    s4_nxt.a   = 64'(sums.r2) * 64'(cfg.mk1);
    s4_nxt.b   = 64'(sums.r2) * 64'(cfg.mk2);
    s4_nxt.q1x = 65'(sums.t1) * 65'(cfg.mp1);
    s4_nxt.q2x = 65'(sums.uv2) * 65'(cfg.mp2);
    s4_nxt.q1y = 65'(sums.uv2) * 65'(cfg.mp1);
    s4_nxt.q2y = 65'(sums.t2) * 65'(cfg.mp2);
  end

  // partial products, tangential rounding
  always_comb begin
    s5_nxt.p   = s4_r.p;
    s5_nxt.cl  = 65'(s4_r.r2) * 65'(s4_r.b[31:0]);
    s5_nxt.ch  = 65'(s4_r.r2) * 65'(s4_r.b[63:32]);
    s5_nxt.xl  = 48'(s4_r.p.au) * 48'(s4_r.a[31:0]);
    s5_nxt.xh  = 48'(s4_r.p.au) * 48'(s4_r.a[63:32]);
    s5_nxt.yl  = 48'(s4_r.p.av) * 48'(s4_r.a[31:0]);
    s5_nxt.yh  = 48'(s4_r.p.av) * 48'(s4_r.a[63:32]);
    s5_nxt.p1x = ldpm_pkg::round_pt(s4_r.q1x);
    s5_nxt.p2x = ldpm_pkg::round_pt(s4_r.q2x);
    s5_nxt.p1y = ldpm_pkg::round_pt(s4_r.q1y);
    s5_nxt.p2y = ldpm_pkg::round_pt(s4_r.q2y);
  end

  // combine partials, k1 rounding
  always_comb begin
    x1 = 81'(s5_r.xl) + (81'(s5_r.xh) << 32) + ldpm_pkg::K1Half;
    y1 = 81'(s5_r.yl) + (81'(s5_r.yh) << 32) + ldpm_pkg::K1Half;
    s6_nxt.p   = s5_r.p;
    s6_nxt.c   = 97'(s5_r.cl) + (97'(s5_r.ch) << 32);
    s6_nxt.k1x = x1[80:ldpm_pkg::K1Shift];
    s6_nxt.k1y = y1[80:ldpm_pkg::K1Shift];
    s6_nxt.p1x = s5_r.p1x;
    s6_nxt.p2x = s5_r.p2x;
    s6_nxt.p1y = s5_r.p1y;
    s6_nxt.p2y = s5_r.p2y;
  end

  // offset times k2 r2 squared, in three slices
  always_comb begin
    s7_nxt.p   = s6_r.p;
    s7_nxt.k1x = s6_r.k1x;
    s7_nxt.k1y = s6_r.k1y;
    s7_nxt.p1x = s6_r.p1x;
    s7_nxt.p2x = s6_r.p2x;
    s7_nxt.p1y = s6_r.p1y;
    s7_nxt.p2y = s6_r.p2y;
    s7_nxt.d0x = 49'(s6_r.p.au) * 49'(s6_r.c[32:0]);
    s7_nxt.d1x = 49'(s6_r.p.au) * 49'(s6_r.c[65:33]);
    s7_nxt.d2x = 47'(s6_r.p.au) * 47'(s6_r.c[96:66]);
    s7_nxt.d0y = 49'(s6_r.p.av) * 49'(s6_r.c[32:0]);
    s7_nxt.d1y = 49'(s6_r.p.av) * 49'(s6_r.c[65:33]);
    s7_nxt.d2y = 47'(s6_r.p.av) * 47'(s6_r.c[96:66]);
  end

  // k2 rounding
  always_comb begin
    dx = 114'(s7_r.d0x) + (114'(s7_r.d1x) << 33) + (114'(s7_r.d2x) << 66)
       + ldpm_pkg::K2Half;
    dy = 114'(s7_r.d0y) + (114'(s7_r.d1y) << 33) + (114'(s7_r.d2y) << 66)
       + ldpm_pkg::K2Half;
    s8_nxt.nu  = s7_r.p.nu;
    s8_nxt.nv  = s7_r.p.nv;
    s8_nxt.bx  = s7_r.p.bx;
    s8_nxt.by  = s7_r.p.by;
    s8_nxt.k1x = s7_r.k1x;
    s8_nxt.k1y = s7_r.k1y;
    s8_nxt.k2x = dx[113:ldpm_pkg::K2Shift];
    s8_nxt.k2y = dy[113:ldpm_pkg::K2Shift];
    s8_nxt.p1x = s7_r.p1x;
    s8_nxt.p2x = s7_r.p2x;
    s8_nxt.p1y = s7_r.p1y;
    s8_nxt.p2y = s7_r.p2y;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_r <= s4_nxt;
    end
    if (en[1]) begin
      s5_r <= s5_nxt;
    end
    if (en[2]) begin
      s6_r <= s6_nxt;
    end
    if (en[3]) begin
      s7_r <= s7_nxt;
    end
    if (en[4]) begin
      s8_r <= s8_nxt;
    end
  end

  assign terms = s8_r;

endmodule

`default_nettype wire

@@ sv/ldpm_sum.sv @@
`default_nettype none

module ldpm_sum (
  input  wire logic                           clk,
  input  wire logic [ldpm_pkg::SumStages-1:0] en,
  input  wire ldpm_pkg::cfg_t                 cfg,
  input  wire ldpm_pkg::terms_t               terms,
  output logic [15:0]                         out_x,
  output logic [15:0]                         out_y,
  output logic                                out_saturated
);

  logic [25:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic        sat_r, sat_nxt;
  logic        nuv, hix, lox, hiy, loy;

  // signed sum of the four terms per axis
  always_comb begin
    nuv = terms.nu ^ terms.nv;
    sx_nxt = {{9{terms.bx[16]}}, terms.bx}
           + ldpm_pkg::apply_sign({1'b0, terms.k1x}, cfg.nk1 ^ terms.nu)
           + ldpm_pkg::apply_sign(terms.k2x, cfg.nk2 ^ terms.nu)
           + ldpm_pkg::apply_sign(terms.p1x, cfg.np1)
           + ldpm_pkg::apply_sign(terms.p2x, cfg.np2 ^ nuv);
    sy_nxt = {{9{terms.by[16]}}, terms.by}
           + ldpm_pkg::apply_sign({1'b0, terms.k1y}, cfg.nk1 ^ terms.nv)
           + ldpm_pkg::apply_sign(terms.k2y, cfg.nk2 ^ terms.nv)
           + ldpm_pkg::apply_sign(terms.p1y, cfg.np1 ^ nuv)
           + ldpm_pkg::apply_sign(terms.p2y, cfg.np2);
  end

  // saturate to 16 bits
  always_comb begin
    hix = !sx_r[25] && (sx_r[24:15] != 10'd0);
    lox = sx_r[25] && (sx_r[24:15] != 10'h3ff);
    hiy = !sy_r[25] && (sy_r[24:15] != 10'd0);
    loy = sy_r[25] && (sy_r[24:15] != 10'h3ff);
    ox_nxt = hix ? 16'h7fff : (lox ? 16'h8000 : sx_r[15:0]);
    oy_nxt = hiy ? 16'h7fff : (loy ? 16'h8000 : sy_r[15:0]);
    sat_nxt = hix | lox | hiy | loy;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (en[1]) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_x = ox_r;
  assign out_y = oy_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

@@ sv/lens_distortion_point_map_top.sv @@
// Lens distortion point map: applies a two-radial, two-tangential lens model
// to one Q12.4 pixel coordinate about a configured center.
// Input channel (in_valid/in_ready) carries in_x, in_y and a target point;
// in residual mode the target is subtracted from the distorted point.
// Output channel (out_valid/out_ready) returns out_x, out_y, saturated to
// the 16-bit range, and out_saturated when either axis was clipped.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes one
// register per transfer by index; unknown indexes are dropped. Write only
// while no item is in flight.
// The pipeline has ten register stages from the input transfer to the output.
// Throughput: one item per cycle while the receiver accepts results.
// Reset clears all coefficients, the center and the mode, and empties the
// pipeline. When the receiver stalls, the output register holds its result
// and earlier stages keep filling bubbles; in_ready drops only once every
// stage holds an item.
`default_nettype none

module lens_distortion_point_map_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_x,
  input  wire logic [15:0] in_y,
  input  wire logic [15:0] in_target_x,
  input  wire logic [15:0] in_target_y,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic             out_saturated,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int N = ldpm_pkg::NumStages;
  localparam int PrepEnd = ldpm_pkg::PrepStages;
  localparam int ProdEnd = PrepEnd + ldpm_pkg::ProdStages;

  ldpm_pkg::cfg_t   cfg_r, cfg_nxt;
  ldpm_pkg::sums_t  sums;
  ldpm_pkg::terms_t terms;

  logic [N-1:0] vld_r, vld_nxt, en;

  // config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (ldpm_pkg::cfg_reg_t'(cfg_index))
        ldpm_pkg::RegK1: begin
          cfg_nxt.mk1 = ldpm_pkg::mag32(cfg_data);
          cfg_nxt.nk1 = cfg_data[31];
        end
        ldpm_pkg::RegK2: begin
          cfg_nxt.mk2 = ldpm_pkg::mag32(cfg_data);
          cfg_nxt.nk2 = cfg_data[31];
        end
        ldpm_pkg::RegP1: begin
          cfg_nxt.mp1 = ldpm_pkg::mag32(cfg_data);
          cfg_nxt.np1 = cfg_data[31];
        end
        ldpm_pkg::RegP2: begin
          cfg_nxt.mp2 = ldpm_pkg::mag32(cfg_data);
          cfg_nxt.np2 = cfg_data[31];
        end
        ldpm_pkg::RegCx: begin
          cfg_nxt.cx = cfg_data[15:0];
        end
        ldpm_pkg::RegCy: begin
          cfg_nxt.cy = cfg_data[15:0];
        end
        ldpm_pkg::RegMode: begin
          cfg_nxt.mode = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  // stage enables: a stage moves when it is empty or the next one moves
  assign en[N-1] = !vld_r[N-1] || out_ready;

  for (genvar i = 0; i < N - 1; i++) begin : g_en
    assign en[i] = !vld_r[i] || en[i+1];
  end

  assign vld_nxt[0] = en[0] ? in_valid : vld_r[0];

  for (genvar i = 1; i < N; i++) begin : g_vld
    assign vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[N-1];

  ldpm_prep u_prep (
    .clk         (clk),
    .en          (en[PrepEnd-1:0]),
    .cfg         (cfg_r),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_target_x (in_target_x),
    .in_target_y (in_target_y),
    .sums        (sums)
  );

  ldpm_prod u_prod (
    .clk   (clk),
    .en    (en[ProdEnd-1:PrepEnd]),
    .cfg   (cfg_r),
    .sums  (sums),
    .terms (terms)
  );

  ldpm_sum u_sum (
    .clk           (clk),
    .en            (en[N-1:ProdEnd]),
    .cfg           (cfg_r),
    .terms         (terms),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire
